/* design/hysteresis_thermostat_editor_macros.svh */
// ----------------------------------------------------------------------------
// Thermostat editor assertion macros
// Shared concurrent assertion forms. Each form samples on clk_i and is off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_THERMOSTAT_EDITOR_MACROS_SVH
`define HYSTERESIS_THERMOSTAT_EDITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTE_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hte_pkg.sv */
// ----------------------------------------------------------------------------
// Thermostat editor package
// Types, codes, reset values and small arithmetic helpers of the thermostat.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int unsigned TempW    = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_MINUS      = 3'd1,
    OP_PLUS       = 3'd2,
    OP_MINUS_LONG = 3'd3,
    OP_PLUS_LONG  = 3'd4,
    OP_MEASURE    = 3'd5,
    OP_LOAD       = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_LOWER = 2'd1,
    MODE_UPPER = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_LIMIT     = 2'd0,
    CFG_MAX_LIMIT     = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_idx_e;

  localparam logic signed [TempW-1:0] MinLimitRst     = -8'sd50;
  localparam logic signed [TempW-1:0] MaxLimitRst     = 8'sd50;
  localparam logic [TimeoutW-1:0]     TimeoutTicksRst = 16'd2000;

  typedef struct packed {
    logic signed [TempW-1:0] min_limit;
    logic signed [TempW-1:0] max_limit;
    logic [TimeoutW-1:0]     timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [TempW-1:0] temperature;
    logic             measure_ok;
    logic [TempW-1:0] stored_lower;
    logic [TempW-1:0] stored_upper;
  } in_item_t;

  typedef struct packed {
    logic             relay_on;
    logic             sensor_fault;
    logic [TempW-1:0] lower_out;
    logic [TempW-1:0] upper_out;
    logic [1:0]       edit_mode;
    logic [TempW-1:0] edit_value;
    logic             save_strobe;
  } out_item_t;

  function automatic logic signed [TempW-1:0] sat8(input logic signed [TempW:0] v);
    logic signed [TempW-1:0] r;
    if (v < -9'sd128) begin
      r = -8'sd128;
    end else if (v > 9'sd127) begin
      r = 8'sd127;
    end else begin
      r = v[TempW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [TempW-1:0] clamp8(input logic signed [TempW-1:0] v,
                                                     input logic signed [TempW-1:0] lo,
                                                     input logic signed [TempW-1:0] hi);
    logic signed [TempW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* design/hte_if.sv */
// ----------------------------------------------------------------------------
// Thermostat editor channels
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface hte_in_if import hte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              opcode;
  logic signed [TempW-1:0] temperature;
  logic                    measure_ok;
  logic signed [TempW-1:0] stored_lower;
  logic signed [TempW-1:0] stored_upper;

  modport source (
    output valid, opcode, temperature, measure_ok, stored_lower, stored_upper,
    input  ready
  );
  modport sink (
    input  valid, opcode, temperature, measure_ok, stored_lower, stored_upper,
    output ready
  );
endinterface

interface hte_out_if import hte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    relay_on;
  logic                    sensor_fault;
  logic signed [TempW-1:0] lower_out;
  logic signed [TempW-1:0] upper_out;
  logic [1:0]              edit_mode;
  logic signed [TempW-1:0] edit_value;
  logic                    save_strobe;

  modport source (
    output valid, relay_on, sensor_fault, lower_out, upper_out, edit_mode, edit_value,
           save_strobe,
    input  ready
  );
  modport sink (
    input  valid, relay_on, sensor_fault, lower_out, upper_out, edit_mode, edit_value,
           save_strobe,
    output ready
  );
endinterface

/* design/hte_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Thermostat editor configuration registers
// Holds the threshold limits and the edit timeout, written by index.
// ----------------------------------------------------------------------------
module hte_cfg_regs import hte_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_LIMIT:     cfg_d.min_limit     = cfg_data_i[TempW-1:0];
        CFG_MAX_LIMIT:     cfg_d.max_limit     = cfg_data_i[TempW-1:0];
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_limit     <= MinLimitRst;
      cfg_q.max_limit     <= MaxLimitRst;
      cfg_q.timeout_ticks <= TimeoutTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/hte_core.sv */
// ----------------------------------------------------------------------------
// Thermostat editor core
// Holds the thresholds, relay and edit state, and works out one command
// item per cycle while step_i is high into its result item.
// ----------------------------------------------------------------------------
module hte_core import hte_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  localparam int unsigned CmpW = (COUNT_BITS > TimeoutW) ? COUNT_BITS : TimeoutW;

  logic signed [TempW-1:0] lower_d, lower_q;
  logic signed [TempW-1:0] upper_d, upper_q;
  logic signed [TempW-1:0] pending_d, pending_q;
  logic                    relay_d, relay_q;
  mode_e                   mode_d, mode_q;
  logic [COUNT_BITS-1:0]   idle_d, idle_q;

  logic signed [TempW-1:0] min_lim, max_lim, temp, st_lower, st_upper;
  logic signed [TempW-1:0] lo_min, lo_max, up_min, up_max, b_lo, b_hi;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    fault, save;

  assign min_lim  = cfg_i.min_limit;
  assign max_lim  = cfg_i.max_limit;
  assign temp     = item_i.temperature;
  assign st_lower = item_i.stored_lower;
  assign st_upper = item_i.stored_upper;

  assign lo_min  = min_lim;
  assign lo_max  = sat8($signed({max_lim[TempW-1], max_lim}) - 9'sd1);
  assign up_min  = sat8($signed({min_lim[TempW-1], min_lim}) + 9'sd1);
  assign up_max  = max_lim;
  assign b_lo    = (mode_q == MODE_LOWER) ? lo_min : up_min;
  assign b_hi    = (mode_q == MODE_LOWER) ? lo_max : up_max;
  assign cnt_inc = (idle_q != '1) ? idle_q + 1'b1 : idle_q;

  always_comb begin
    lower_d   = lower_q;
    upper_d   = upper_q;
    pending_d = pending_q;
    relay_d   = relay_q;
    mode_d    = mode_q;
    idle_d    = idle_q;
    fault     = 1'b0;
    save      = 1'b0;
    case (op_e'(item_i.opcode))
      OP_TICK: begin
        if (mode_q != MODE_NONE) begin
          idle_d = cnt_inc;
          if (CmpW'(cnt_inc) >= CmpW'(cfg_i.timeout_ticks)) begin
            if (mode_q == MODE_LOWER) begin
              lower_d = pending_q;
              if (upper_q <= pending_q) begin
                upper_d = sat8($signed({pending_q[TempW-1], pending_q}) + 9'sd1);
              end
            end else begin
              upper_d = pending_q;
              if (lower_q >= pending_q) begin
                lower_d = sat8($signed({pending_q[TempW-1], pending_q}) - 9'sd1);
              end
            end
            mode_d    = MODE_NONE;
            pending_d = '0;
            save      = 1'b1;
          end
        end
      end
      OP_MINUS, OP_PLUS: begin
        if (mode_q != MODE_NONE) begin
          if (op_e'(item_i.opcode) == OP_MINUS) begin
            if (pending_q > b_lo) pending_d = pending_q - 8'sd1;
          end else begin
            if (pending_q < b_hi) pending_d = pending_q + 8'sd1;
          end
          idle_d = '0;
        end
      end
      OP_MINUS_LONG, OP_PLUS_LONG: begin
        if (mode_q == MODE_NONE) begin
          if (op_e'(item_i.opcode) == OP_MINUS_LONG) begin
            mode_d    = MODE_LOWER;
            pending_d = lower_q;
          end else begin
            mode_d    = MODE_UPPER;
            pending_d = upper_q;
          end
          idle_d = '0;
        end
      end
      OP_MEASURE: begin
        if (mode_q == MODE_NONE) begin
          if (!item_i.measure_ok) begin
            relay_d = 1'b1;
            fault   = 1'b1;
          end else if (temp <= lower_q) begin
            relay_d = 1'b1;
          end else if (temp >= upper_q) begin
            relay_d = 1'b0;
          end
        end
      end
      OP_LOAD: begin
        lower_d = clamp8(st_lower, lo_min, lo_max);
        upper_d = clamp8(st_upper, up_min, up_max);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q   <= MinLimitRst;
      upper_q   <= MaxLimitRst;
      pending_q <= '0;
      relay_q   <= 1'b1;
      mode_q    <= MODE_NONE;
      idle_q    <= '0;
    end else if (step_i) begin
      lower_q   <= lower_d;
      upper_q   <= upper_d;
      pending_q <= pending_d;
      relay_q   <= relay_d;
      mode_q    <= mode_d;
      idle_q    <= idle_d;
    end
  end

  always_comb begin
    result_o.relay_on     = relay_d;
    result_o.sensor_fault = fault;
    result_o.lower_out    = lower_d;
    result_o.upper_out    = upper_d;
    result_o.edit_mode    = mode_d;
    result_o.edit_value   = (mode_d != MODE_NONE) ? pending_d : '0;
    result_o.save_strobe  = save;
  end

endmodule

/* design/hysteresis_thermostat_editor.sv */
// ----------------------------------------------------------------------------
// Hysteresis thermostat editor
// Two-point thermostat with threshold editing by key presses and timeout.
//
//   Channel   Dir   Transfer when         Carries
//   in_i      in    in_i.valid & ready    command item
//   out_o     out   out_o.valid & ready   relay, thresholds, edit state
//   cfg       in    cfg_we_i              limits and timeout, by index
//
// One item per cycle unless the result stalls: a command item is held in the
// input register, then the core logic writes its result to the output
// register. A stalled result holds the output register; the input register
// refills as soon as its item moves on. Reset is asynchronous and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_editor import hte_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hte_in_if.sink              in_i,
  hte_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_item_q;
  out_item_t out_item_q, result;
  logic      in_valid_d, in_valid_q, out_valid_d, out_valid_q;
  logic      in_fire, step, out_free;

  hte_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  hte_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || step;
  assign in_fire    = in_i.valid && in_i.ready;

  assign in_valid_d  = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.opcode       <= in_i.opcode;
      in_item_q.temperature  <= in_i.temperature;
      in_item_q.measure_ok   <= in_i.measure_ok;
      in_item_q.stored_lower <= in_i.stored_lower;
      in_item_q.stored_upper <= in_i.stored_upper;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.relay_on     = out_item_q.relay_on;
  assign out_o.sensor_fault = out_item_q.sensor_fault;
  assign out_o.lower_out    = out_item_q.lower_out;
  assign out_o.upper_out    = out_item_q.upper_out;
  assign out_o.edit_mode    = out_item_q.edit_mode;
  assign out_o.edit_value   = out_item_q.edit_value;
  assign out_o.save_strobe  = out_item_q.save_strobe;

endmodule

/* design/hte_checker.sv */
// ----------------------------------------------------------------------------
// Thermostat editor port checker
// Watches the top-level ports for consistency of result items over time.
// ----------------------------------------------------------------------------
`include "hysteresis_thermostat_editor_macros.svh"

module hte_checker import hte_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             relay_on_i,
  input logic             sensor_fault_i,
  input logic [TempW-1:0] lower_out_i,
  input logic [TempW-1:0] upper_out_i,
  input logic [1:0]       edit_mode_i,
  input logic [TempW-1:0] edit_value_i,
  input logic             save_strobe_i
);

  // A failed measurement is only taken outside an edit and forces the relay on.
  `HTE_ASSERT_SAME(a_fault_relay, out_valid_i && sensor_fault_i, relay_on_i && (edit_mode_i == MODE_NONE), "fault without relay on or while editing")

  // A commit closes the edit.
  `HTE_ASSERT_SAME(a_save_closes, out_valid_i && save_strobe_i, (edit_mode_i == MODE_NONE) && (edit_value_i == '0), "save strobe while still editing")

  // Outside an edit the edit value reads zero.
  `HTE_ASSERT_SAME(a_idle_value, out_valid_i && (edit_mode_i == MODE_NONE), edit_value_i == '0, "edit value shown while not editing")

  // A stalled result stays put until its transfer.
  `HTE_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable({relay_on_i, sensor_fault_i, lower_out_i, upper_out_i, edit_mode_i, edit_value_i, save_strobe_i}), "stalled result changed")

endmodule

bind hysteresis_thermostat_editor hte_checker u_hte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .relay_on_i     (out_o.relay_on),
  .sensor_fault_i (out_o.sensor_fault),
  .lower_out_i    (out_o.lower_out),
  .upper_out_i    (out_o.upper_out),
  .edit_mode_i    (out_o.edit_mode),
  .edit_value_i   (out_o.edit_value),
  .save_strobe_i  (out_o.save_strobe)
);

/* tb/sv/hysteresis_thermostat_editor_tb.sv */
// ----------------------------------------------------------------------------
// Hysteresis thermostat editor testbench
// Drives command items through the input channel and predicts each status
// item from a local copy of the thresholds, relay, edit state and limits.
// Every status transfer is checked against the oldest prediction. Directed
// tests cover the temperature extremes, faults, ignored commands, crossed and
// saturated limits and limit changes during an edit. Random traffic then
// mixes edit sessions, measurements, loads and noise with random sender gaps
// and result stalls, and the run ends with a long commit timeout.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_editor_tb;
  import hte_pkg::*;

  localparam logic [2:0] OpUnused      = 3'd7;
  localparam int         WatchdogLimit = 1000;
  localparam int         ShownMax      = 10;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  hte_in_if  cmd_ch ();
  hte_out_if status_ch ();

  hysteresis_thermostat_editor uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (cmd_ch),
    .out_o     (status_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  logic signed [TempW-1:0] lim_min;
  logic signed [TempW-1:0] lim_max;
  logic [TimeoutW-1:0]     commit_ticks;
  logic signed [TempW-1:0] thr_lower;
  logic signed [TempW-1:0] thr_upper;
  logic                    relay;
  mode_e                   edit_state;
  logic signed [TempW-1:0] edit_pending;
  logic [15:0]             idle_ticks;

  out_item_t predicted_status[$];
  int mismatch_count = 0;
  int commands_sent  = 0;
  int burst_left     = 0;
  int hold_cycles    = 0;
  int quiet_cycles   = 0;
  bit gaps_on        = 1'b1;
  bit sink_stalls    = 1'b1;

  function automatic logic signed [TempW-1:0] sat_temp(int v);
    if (v < -128) begin
      return -8'sd128;
    end else if (v > 127) begin
      return 8'sd127;
    end
    return v[TempW-1:0];
  endfunction

  function automatic logic signed [TempW-1:0] limit_to(logic signed [TempW-1:0] v,
                                                       logic signed [TempW-1:0] lo,
                                                       logic signed [TempW-1:0] hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic void reset_thermostat();
    lim_min      = -8'sd50;
    lim_max      = 8'sd50;
    commit_ticks = 16'd2000;
    thr_lower    = lim_min;
    thr_upper    = lim_max;
    relay        = 1'b1;
    edit_state   = MODE_NONE;
    edit_pending = '0;
    idle_ticks   = '0;
  endfunction

  function automatic out_item_t predict_thermostat(in_item_t cmd);
    out_item_t               res;
    logic signed [TempW-1:0] bound_lo;
    logic signed [TempW-1:0] bound_hi;
    logic signed [TempW-1:0] temp;
    logic                    fault;
    logic                    save;
    fault = 1'b0;
    save  = 1'b0;
    temp  = $signed(cmd.temperature);
    case (cmd.opcode)
      OP_TICK: begin
        if (edit_state != MODE_NONE) begin
          if (idle_ticks != '1) begin
            idle_ticks++;
          end
          if (idle_ticks >= commit_ticks) begin
            if (edit_state == MODE_LOWER) begin
              thr_lower = edit_pending;
              if (thr_upper <= edit_pending) begin
                thr_upper = sat_temp(int'(edit_pending) + 1);
              end
            end else begin
              thr_upper = edit_pending;
              if (thr_lower >= edit_pending) begin
                thr_lower = sat_temp(int'(edit_pending) - 1);
              end
            end
            edit_state   = MODE_NONE;
            edit_pending = '0;
            save         = 1'b1;
          end
        end
      end
      OP_MINUS, OP_PLUS: begin
        if (edit_state != MODE_NONE) begin
          bound_lo = (edit_state == MODE_LOWER) ? lim_min : sat_temp(int'(lim_min) + 1);
          bound_hi = (edit_state == MODE_LOWER) ? sat_temp(int'(lim_max) - 1) : lim_max;
          if (cmd.opcode == OP_MINUS) begin
            if (edit_pending > bound_lo) begin
              edit_pending--;
            end
          end else if (edit_pending < bound_hi) begin
            edit_pending++;
          end
          idle_ticks = '0;
        end
      end
      OP_MINUS_LONG, OP_PLUS_LONG: begin
        if (edit_state == MODE_NONE) begin
          edit_state   = (cmd.opcode == OP_MINUS_LONG) ? MODE_LOWER : MODE_UPPER;
          edit_pending = (cmd.opcode == OP_MINUS_LONG) ? thr_lower : thr_upper;
          idle_ticks   = '0;
        end
      end
      OP_MEASURE: begin
        if (edit_state == MODE_NONE) begin
          if (!cmd.measure_ok) begin
            relay = 1'b1;
            fault = 1'b1;
          end else if (temp <= thr_lower) begin
            relay = 1'b1;
          end else if (temp >= thr_upper) begin
            relay = 1'b0;
          end
        end
      end
      OP_LOAD: begin
        thr_lower = limit_to($signed(cmd.stored_lower), lim_min,
                             sat_temp(int'(lim_max) - 1));
        thr_upper = limit_to($signed(cmd.stored_upper), sat_temp(int'(lim_min) + 1),
                             lim_max);
      end
      default: begin
      end
    endcase
    res.relay_on     = relay;
    res.sensor_fault = fault;
    res.lower_out    = thr_lower;
    res.upper_out    = thr_upper;
    res.edit_mode    = edit_state;
    res.edit_value   = (edit_state != MODE_NONE) ? edit_pending : '0;
    res.save_strobe  = save;
    return res;
  endfunction

  function automatic string status_str(out_item_t s);
    return $sformatf("relay=%0b fault=%0b lower=%0d upper=%0d mode=%0d value=%0d save=%0b",
                     s.relay_on, s.sensor_fault, $signed(s.lower_out), $signed(s.upper_out),
                     s.edit_mode, $signed(s.edit_value), s.save_strobe);
  endfunction

  task automatic send_cmd(input logic [2:0] op, input logic [TempW-1:0] temp, input logic ok,
                          input logic [TempW-1:0] s_lower, input logic [TempW-1:0] s_upper);
    in_item_t cmd;
    if (gaps_on && burst_left == 0) begin
      @(negedge clk_i);
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    cmd.opcode       = op;
    cmd.temperature  = temp;
    cmd.measure_ok   = ok;
    cmd.stored_lower = s_lower;
    cmd.stored_upper = s_upper;
    @(negedge clk_i);
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= op;
    cmd_ch.temperature  <= temp;
    cmd_ch.measure_ok   <= ok;
    cmd_ch.stored_lower <= s_lower;
    cmd_ch.stored_upper <= s_upper;
    do begin
      @(posedge clk_i);
    end while (cmd_ch.ready !== 1'b1);
    predicted_status.push_back(predict_thermostat(cmd));
    commands_sent++;
  endtask

  task automatic send_op(input logic [2:0] op);
    send_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_measure();
    int t;
    case ($urandom_range(0, 3))
      0:       t = $urandom_range(0, 255);
      1:       t = int'(thr_lower) + $urandom_range(0, 4) - 2;
      2:       t = int'(thr_upper) + $urandom_range(0, 4) - 2;
      default: t = int'(thr_lower) + $urandom_range(0, 255);
    endcase
    send_cmd(OP_MEASURE, 8'(t), $urandom_range(0, 7) != 0, 8'($urandom), 8'($urandom));
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (predicted_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_LIMIT:     lim_min = data[TempW-1:0];
      CFG_MAX_LIMIT:     lim_max = data[TempW-1:0];
      CFG_TIMEOUT_TICKS: commit_ticks = data;
      default: begin
      end
    endcase
  endtask

  task automatic apply_config(input int lo, input int hi, input int ticks);
    logic [7:0] junk;
    quiesce();
    junk = 8'($urandom);
    write_reg(CFG_MIN_LIMIT, {junk, 8'(lo)});
    junk = 8'($urandom);
    write_reg(CFG_MAX_LIMIT, {junk, 8'(hi)});
    write_reg(CFG_TIMEOUT_TICKS, 16'(ticks));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_edit_session();
    logic [2:0] dir;
    int         r;
    int         ticks;
    send_op($urandom_range(0, 1) ? OP_MINUS_LONG : OP_PLUS_LONG);
    dir = $urandom_range(0, 1) ? OP_MINUS : OP_PLUS;
    repeat ($urandom_range(0, 12)) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        send_op(dir);
      end else if (r == 6) begin
        send_op(dir == OP_MINUS ? OP_PLUS : OP_MINUS);
      end else if (r == 7) begin
        send_measure();
      end else if (r == 8) begin
        send_op(OP_LOAD);
      end else begin
        send_op(OP_TICK);
      end
    end
    ticks = (commit_ticks == 0) ? 1 : commit_ticks;
    if ($urandom_range(0, 7) != 0) begin
      repeat (ticks) send_op(OP_TICK);
    end
  endtask

  task automatic test_reset_and_measure();
    send_cmd(OP_MEASURE, 8'sd0, 1'b1, 8'h00, 8'h00);
    send_cmd(OP_MEASURE, 8'sd127, 1'b1, 8'hFF, 8'hFF);
    send_cmd(OP_MEASURE, -8'sd128, 1'b1, 8'h00, 8'hFF);
    send_cmd(OP_MEASURE, 8'sd50, 1'b1, 8'hAA, 8'h55);
    send_cmd(OP_MEASURE, -8'sd50, 1'b1, 8'h55, 8'hAA);
    send_cmd(OP_MEASURE, 8'sd127, 1'b0, 8'h00, 8'h00);
    send_op(OP_MINUS);
    send_op(OP_PLUS);
    send_op(OP_TICK);
    send_op(OpUnused);
    send_cmd(OP_LOAD, 8'h00, 1'b0, -8'sd128, 8'sd127);
    send_cmd(OP_LOAD, 8'hFF, 1'b1, 8'sd127, -8'sd128);
  endtask

  task automatic test_edit_at_wide_limits();
    apply_config(-128, 127, 2);
    send_cmd(OP_LOAD, 8'h00, 1'b0, -8'sd128, -8'sd128);
    send_op(OP_MINUS_LONG);
    send_op(OP_MINUS);
    send_op(OP_PLUS_LONG);
    send_cmd(OP_MEASURE, -8'sd128, 1'b0, 8'h00, 8'h00);
    send_op(OP_PLUS);
    send_cmd(OP_LOAD, 8'h00, 1'b1, 8'sd0, 8'sd126);
    send_op(OP_TICK);
    send_op(OP_TICK);
  endtask

  task automatic test_crossed_limits();
    apply_config(127, -128, 0);
    send_cmd(OP_LOAD, 8'h00, 1'b0, 8'sd0, 8'sd0);
    send_op(OP_MINUS_LONG);
    send_op(OP_MINUS);
    send_op(OP_TICK);
    send_cmd(OP_LOAD, 8'h00, 1'b0, 8'sd127, 8'sd127);
    send_op(OP_PLUS_LONG);
    send_op(OP_PLUS);
    send_op(OP_TICK);
  endtask

  task automatic test_limits_changed_during_edit();
    apply_config(-50, 50, 1);
    send_op(OP_MINUS_LONG);
    apply_config(0, 10, 1);
    send_op(OP_MINUS);
    send_op(OP_PLUS);
    send_op(OP_TICK);
  endtask

  task automatic test_random_traffic();
    int phase;
    int start;
    int r;
    int m;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_config(-50, 50, $urandom_range(1, 4));
        1: begin
          m = int'($urandom_range(0, 250)) - 128;
          apply_config(m, m + int'($urandom_range(1, 4)), $urandom_range(0, 3));
        end
        2: apply_config(-128, 127, $urandom_range(2, 6));
        3: apply_config(int'($urandom_range(0, 255)) - 128,
                        int'($urandom_range(0, 255)) - 128, $urandom_range(1, 5));
        4: apply_config(123, 127, 1);
        default: apply_config(-128, -124, $urandom_range(1, 3));
      endcase
      gaps_on     = (phase != 2 && phase != 4);
      sink_stalls = (phase != 2 && phase != 5);
      start = commands_sent;
      while (commands_sent - start < 260) begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          run_edit_session();
        end else if (r < 7) begin
          repeat ($urandom_range(1, 5)) send_measure();
        end else if (r == 7) begin
          send_op(OP_LOAD);
        end else if (r == 8) begin
          send_op(3'($urandom_range(0, 7)));
        end else begin
          send_op(OP_TICK);
        end
      end
    end
  endtask

  task automatic test_input_backpressure();
    apply_config(-50, 50, 2);
    gaps_on     = 1'b0;
    sink_stalls = 1'b0;
    hold_cycles = 60;
    repeat (40) send_op(3'($urandom_range(0, 7)));
  endtask

  task automatic test_long_timeout();
    apply_config(-20, 20, 200);
    gaps_on     = 1'b0;
    sink_stalls = 1'b0;
    send_op(OP_PLUS_LONG);
    send_op(OP_MINUS);
    repeat (200) send_op(OP_TICK);
  endtask

  initial begin : status_sink
    int  run_left;
    bit  level;
    run_left = 0;
    level    = 1'b1;
    status_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        status_ch.ready <= 1'b0;
      end else if (!sink_stalls) begin
        status_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          level    = !level;
          run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        run_left--;
        status_ch.ready <= level;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && status_ch.valid && status_ch.ready) begin
      got.relay_on     = status_ch.relay_on;
      got.sensor_fault = status_ch.sensor_fault;
      got.lower_out    = status_ch.lower_out;
      got.upper_out    = status_ch.upper_out;
      got.edit_mode    = status_ch.edit_mode;
      got.edit_value   = status_ch.edit_value;
      got.save_strobe  = status_ch.save_strobe;
      if (predicted_status.size() == 0) begin
        if (mismatch_count < ShownMax) begin
          $display("Unexpected status transfer: %s", status_str(got));
        end
        mismatch_count++;
      end else begin
        want = predicted_status.pop_front();
        if (got !== want) begin
          if (mismatch_count < ShownMax) begin
            $display("Status mismatch at %0t:\n  expected %s\n  actual   %s",
                     $realtime, status_str(want), status_str(got));
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("hysteresis_thermostat_editor test failed");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_MIN_LIMIT;
    cfg_data_i          = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.opcode       = OP_TICK;
    cmd_ch.temperature  = '0;
    cmd_ch.measure_ok   = 1'b0;
    cmd_ch.stored_lower = '0;
    cmd_ch.stored_upper = '0;
    reset_thermostat();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_and_measure();
    test_edit_at_wide_limits();
    test_crossed_limits();
    test_limits_changed_during_edit();
    test_random_traffic();
    test_input_backpressure();
    test_long_timeout();

    quiesce();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_status.size() == 0) begin
      $display("hysteresis_thermostat_editor test passed");
    end else begin
      $display("hysteresis_thermostat_editor test failed");
    end
    $finish;
  end

endmodule
